>>> rtl/core/biq_pkg.sv
// ----------------------------------------------------------------------------
// biq_pkg
// shared constants, register codes, microcode format and program rom for the
// cascaded biquad iir filter core
// ----------------------------------------------------------------------------
`default_nettype none

package biq_pkg;

    // default sizing
    localparam int MAX_SECTIONS_DEF   = 4;
    localparam int SAMPLE_BITS_DEF    = 16;
    localparam int STATE_BITS_DEF     = 24;
    localparam int COEF_FRAC_BITS_DEF = 14;

    // coefficient packing is fixed by the register layout
    localparam int COEF_W        = 16;
    localparam int PACK_SECTIONS = 4;
    localparam int USED_W        = 4;

    // configuration port
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_COUNT_W = 3;
    localparam int CFG_MASK_W  = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_SECTION_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DC_ZERO_MASK  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_B0       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_B1       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_B2       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_A1       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_A2       = 3'd6;

    localparam logic [CFG_COUNT_W-1:0] COUNT_RESET = 3'd1;
    localparam logic [CFG_MASK_W-1:0]  MASK_RESET  = 4'd0;
    localparam logic [CFG_DATA_W-1:0]  B0_RESET    = 64'd4611756387845323776;

    typedef struct packed {
        logic [CFG_COUNT_W-1:0] count;
        logic [CFG_MASK_W-1:0]  dc_mask;
        logic [CFG_DATA_W-1:0]  b0;
        logic [CFG_DATA_W-1:0]  b1;
        logic [CFG_DATA_W-1:0]  b2;
        logic [CFG_DATA_W-1:0]  a1;
        logic [CFG_DATA_W-1:0]  a2;
    } t_cfg;

    // coefficient / operand select
    localparam int CS_W = 3;
    localparam logic [CS_W-1:0] CS_B0 = 3'd0;
    localparam logic [CS_W-1:0] CS_B1 = 3'd1;
    localparam logic [CS_W-1:0] CS_B2 = 3'd2;
    localparam logic [CS_W-1:0] CS_A1 = 3'd3;
    localparam logic [CS_W-1:0] CS_A2 = 3'd4;

    // hold conditions
    localparam int HC_W = 2;
    localparam logic [HC_W-1:0] HC_NONE = 2'd0;
    localparam logic [HC_W-1:0] HC_IN   = 2'd1;
    localparam logic [HC_W-1:0] HC_OUT  = 2'd2;

    // jump conditions
    localparam int JC_W = 2;
    localparam logic [JC_W-1:0] JC_NEVER    = 2'd0;
    localparam logic [JC_W-1:0] JC_ALWAYS   = 2'd1;
    localparam logic [JC_W-1:0] JC_NO_SEC   = 2'd2;
    localparam logic [JC_W-1:0] JC_MORE_SEC = 2'd3;

    // program steps
    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] SP_IDLE = 4'd0;
    localparam logic [STEP_W-1:0] SP_MB0  = 4'd1;
    localparam logic [STEP_W-1:0] SP_MB1  = 4'd2;
    localparam logic [STEP_W-1:0] SP_MB2  = 4'd3;
    localparam logic [STEP_W-1:0] SP_MA1  = 4'd4;
    localparam logic [STEP_W-1:0] SP_MA2  = 4'd5;
    localparam logic [STEP_W-1:0] SP_ACC  = 4'd6;
    localparam logic [STEP_W-1:0] SP_FIN  = 4'd7;
    localparam logic [STEP_W-1:0] SP_OUT  = 4'd8;

    typedef struct packed {
        logic              in_rdy;
        logic [CS_W-1:0]   coef_sel;
        logic              mul_en;
        logic              mul_neg;
        logic              acc_en;
        logic              acc_clr;
        logic              prime;
        logic              fin;
        logic              out_ld;
        logic [HC_W-1:0]   hold;
        logic [JC_W-1:0]   jc;
        logic [STEP_W-1:0] target;
    } t_uword;

    typedef struct packed {
        logic            in_rdy;
        logic [CS_W-1:0] coef_sel;
        logic            mul_en;
        logic            mul_neg;
        logic            acc_en;
        logic            acc_clr;
        logic            prime;
        logic            fin;
        logic            out_ld;
    } t_ctrl;

    typedef struct packed {
        logic in_valid;
        logic out_block;
        logic no_sec;
        logic last_sec;
    } t_stat;

    function automatic t_uword biq_ucode(input logic [STEP_W-1:0] step);
        t_uword w;
        w = '0;
        case (step)
            SP_IDLE: begin
                w.in_rdy = 1'b1;
                w.hold   = HC_IN;
                w.jc     = JC_NO_SEC;
                w.target = SP_OUT;
            end
            SP_MB0: begin
                w.prime    = 1'b1;
                w.mul_en   = 1'b1;
                w.coef_sel = CS_B0;
            end
            SP_MB1: begin
                w.acc_en   = 1'b1;
                w.acc_clr  = 1'b1;
                w.mul_en   = 1'b1;
                w.coef_sel = CS_B1;
            end
            SP_MB2: begin
                w.acc_en   = 1'b1;
                w.mul_en   = 1'b1;
                w.coef_sel = CS_B2;
            end
            SP_MA1: begin
                w.acc_en   = 1'b1;
                w.mul_en   = 1'b1;
                w.mul_neg  = 1'b1;
                w.coef_sel = CS_A1;
            end
            SP_MA2: begin
                w.acc_en   = 1'b1;
                w.mul_en   = 1'b1;
                w.mul_neg  = 1'b1;
                w.coef_sel = CS_A2;
            end
            SP_ACC: begin
                w.acc_en = 1'b1;
            end
            SP_FIN: begin
                w.fin    = 1'b1;
                w.jc     = JC_MORE_SEC;
                w.target = SP_MB0;
            end
            SP_OUT: begin
                w.out_ld = 1'b1;
                w.hold   = HC_OUT;
                w.jc     = JC_ALWAYS;
                w.target = SP_IDLE;
            end
            default: begin
                w.jc     = JC_ALWAYS;
                w.target = SP_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/biq_if.sv
// ----------------------------------------------------------------------------
// biq_if
// valid/ready channels for input samples and filter results
// ----------------------------------------------------------------------------
`default_nettype none

interface biq_in_if #(
    parameter int SAMPLE_BITS = biq_pkg::SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          block_end;

    modport source (output valid, output sample, output block_end, input ready);
    modport sink   (input valid, input sample, input block_end, output ready);
endinterface

interface biq_out_if #(
    parameter int SAMPLE_BITS = biq_pkg::SAMPLE_BITS_DEF
);
    logic                        valid;
    logic                        ready;
    logic signed [SAMPLE_BITS-1:0] filtered;
    logic signed [SAMPLE_BITS:0]   residual;
    logic                        block_end_out;
    logic                        clipped;

    modport source (output valid, output filtered, output residual,
                    output block_end_out, output clipped, input ready);
    modport sink   (input valid, input filtered, input residual,
                    input block_end_out, input clipped, output ready);
endinterface

`default_nettype wire

>>> rtl/core/biq_cfg_regs.sv
// ----------------------------------------------------------------------------
// biq_cfg_regs
// configuration register file with write strobe for history priming
// ----------------------------------------------------------------------------
`default_nettype none

module biq_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [biq_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [biq_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output biq_pkg::t_cfg                  o_cfg,
    output logic                           o_cfg_hit
);
    import biq_pkg::*;

    t_cfg r_cfg;
    logic n_hit;

    always_comb begin
        case (i_cfg_index)
            CFG_SECTION_COUNT, CFG_DC_ZERO_MASK, CFG_COEF_B0, CFG_COEF_B1,
            CFG_COEF_B2, CFG_COEF_A1, CFG_COEF_A2: n_hit = i_cfg_we;
            default: n_hit = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.count   <= COUNT_RESET;
            r_cfg.dc_mask <= MASK_RESET;
            r_cfg.b0      <= B0_RESET;
            r_cfg.b1      <= '0;
            r_cfg.b2      <= '0;
            r_cfg.a1      <= '0;
            r_cfg.a2      <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SECTION_COUNT: r_cfg.count   <= i_cfg_data[CFG_COUNT_W-1:0];
                CFG_DC_ZERO_MASK:  r_cfg.dc_mask <= i_cfg_data[CFG_MASK_W-1:0];
                CFG_COEF_B0:       r_cfg.b0      <= i_cfg_data;
                CFG_COEF_B1:       r_cfg.b1      <= i_cfg_data;
                CFG_COEF_B2:       r_cfg.b2      <= i_cfg_data;
                CFG_COEF_A1:       r_cfg.a1      <= i_cfg_data;
                CFG_COEF_A2:       r_cfg.a2      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg     = r_cfg;
    assign o_cfg_hit = n_hit;

endmodule

`default_nettype wire

>>> rtl/core/biq_useq.sv
// ----------------------------------------------------------------------------
// biq_useq
// microcode sequencer: step counter, program rom, hold and jump logic
// ----------------------------------------------------------------------------
`default_nettype none

module biq_useq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  biq_pkg::t_stat i_stat,
    output biq_pkg::t_ctrl o_ctrl
);
    import biq_pkg::*;

    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;
    t_uword            word;
    logic              hold;
    logic              jump;
    logic              go;

    assign word = biq_ucode(r_step);

    always_comb begin
        case (word.hold)
            HC_IN:   hold = !i_stat.in_valid;
            HC_OUT:  hold = i_stat.out_block;
            default: hold = 1'b0;
        endcase
        case (word.jc)
            JC_ALWAYS:   jump = 1'b1;
            JC_NO_SEC:   jump = i_stat.no_sec;
            JC_MORE_SEC: jump = !i_stat.last_sec;
            default:     jump = 1'b0;
        endcase
        go = !hold;
        if (hold) begin
            n_step = r_step;
        end else if (jump) begin
            n_step = word.target;
        end else begin
            n_step = r_step + STEP_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= SP_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    always_comb begin
        o_ctrl.in_rdy   = word.in_rdy;
        o_ctrl.coef_sel = word.coef_sel;
        o_ctrl.mul_en   = word.mul_en & go;
        o_ctrl.mul_neg  = word.mul_neg;
        o_ctrl.acc_en   = word.acc_en & go;
        o_ctrl.acc_clr  = word.acc_clr;
        o_ctrl.prime    = word.prime & go;
        o_ctrl.fin      = word.fin & go;
        o_ctrl.out_ld   = word.out_ld & go;
    end

endmodule

`default_nettype wire

>>> rtl/core/biq_datapath.sv
// ----------------------------------------------------------------------------
// biq_datapath
// shared multiply-accumulate, section histories and output register
// ----------------------------------------------------------------------------
`default_nettype none

module biq_datapath #(
    parameter int MAX_SECTIONS   = biq_pkg::MAX_SECTIONS_DEF,
    parameter int SAMPLE_BITS    = biq_pkg::SAMPLE_BITS_DEF,
    parameter int STATE_BITS     = biq_pkg::STATE_BITS_DEF,
    parameter int COEF_FRAC_BITS = biq_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  biq_pkg::t_cfg  i_cfg,
    input  logic           i_cfg_hit,
    input  biq_pkg::t_ctrl i_ctrl,
    output biq_pkg::t_stat o_stat,
    biq_in_if.sink         i_in,
    biq_out_if.source      o_out
);
    import biq_pkg::*;

    localparam int SEC_W  = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
    localparam int EXT_W  = (SAMPLE_BITS > STATE_BITS) ? SAMPLE_BITS : STATE_BITS;
    localparam int PROD_W = COEF_W + STATE_BITS;
    localparam int ACC_W  = PROD_W + 3;

    localparam logic [USED_W-1:0] MAX_USED = USED_W'(MAX_SECTIONS);
    localparam logic signed [STATE_BITS-1:0] STATE_MAX = {1'b0, {(STATE_BITS-1){1'b1}}};
    localparam logic signed [STATE_BITS-1:0] STATE_MIN = {1'b1, {(STATE_BITS-1){1'b0}}};
    localparam logic signed [SAMPLE_BITS-1:0] SMP_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SMP_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) << (COEF_FRAC_BITS - 1);

    // per-section coefficient view
    logic signed [COEF_W-1:0] b0_tab [MAX_SECTIONS];
    logic signed [COEF_W-1:0] b1_tab [MAX_SECTIONS];
    logic signed [COEF_W-1:0] b2_tab [MAX_SECTIONS];
    logic signed [COEF_W-1:0] a1_tab [MAX_SECTIONS];
    logic signed [COEF_W-1:0] a2_tab [MAX_SECTIONS];
    logic [MAX_SECTIONS-1:0]  dcz_tab;

    for (genvar n = 0; n < MAX_SECTIONS; n++) begin : g_sec
        if (n < PACK_SECTIONS) begin : g_pack
            assign b0_tab[n]  = i_cfg.b0[COEF_W*n +: COEF_W];
            assign b1_tab[n]  = i_cfg.b1[COEF_W*n +: COEF_W];
            assign b2_tab[n]  = i_cfg.b2[COEF_W*n +: COEF_W];
            assign a1_tab[n]  = i_cfg.a1[COEF_W*n +: COEF_W];
            assign a2_tab[n]  = i_cfg.a2[COEF_W*n +: COEF_W];
            assign dcz_tab[n] = i_cfg.dc_mask[n];
        end else begin : g_zero
            assign b0_tab[n]  = '0;
            assign b1_tab[n]  = '0;
            assign b2_tab[n]  = '0;
            assign a1_tab[n]  = '0;
            assign a2_tab[n]  = '0;
            assign dcz_tab[n] = 1'b0;
        end
    end

    // state
    logic signed [STATE_BITS-1:0] r_hin1  [MAX_SECTIONS];
    logic signed [STATE_BITS-1:0] r_hin2  [MAX_SECTIONS];
    logic signed [STATE_BITS-1:0] r_hout1 [MAX_SECTIONS];
    logic signed [STATE_BITS-1:0] r_hout2 [MAX_SECTIONS];
    logic                         r_prime;
    logic [SEC_W-1:0]             r_sec;

    logic signed [EXT_W-1:0]       r_cur;
    logic signed [SAMPLE_BITS-1:0] r_sample;
    logic                          r_bend;
    logic                          r_clip;
    logic signed [PROD_W-1:0]      r_prod;
    logic                          r_prod_neg;
    logic signed [ACC_W-1:0]       r_acc;

    logic                          r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_filt;
    logic signed [SAMPLE_BITS:0]   r_resid;
    logic                          r_out_bend;
    logic                          r_out_clip;

    // combinational
    logic [USED_W-1:0]             cnt_ext;
    logic [USED_W-1:0]             used;
    logic                          accept;
    logic signed [EXT_W-1:0]       sample_ext;
    logic [EXT_W-STATE_BITS:0]     in_top;
    logic                          in_ovf;
    logic signed [STATE_BITS-1:0]  in_sat;
    logic signed [STATE_BITS-1:0]  cur_st;
    logic signed [COEF_W-1:0]      coef;
    logic signed [STATE_BITS-1:0]  opnd;
    logic signed [PROD_W-1:0]      prod_next;
    logic signed [ACC_W-1:0]       prod_ext;
    logic signed [ACC_W-1:0]       addend;
    logic signed [ACC_W-1:0]       acc_rnd;
    logic signed [ACC_W-1:0]       acc_shr;
    logic [ACC_W-STATE_BITS:0]     acc_top;
    logic                          acc_ovf;
    logic signed [STATE_BITS-1:0]  acc_sat;
    logic [EXT_W-SAMPLE_BITS:0]    filt_top;
    logic                          filt_ovf;
    logic signed [SAMPLE_BITS-1:0] filt_sat;
    logic signed [SAMPLE_BITS:0]   resid;

    assign cnt_ext = USED_W'(i_cfg.count);
    assign used    = (cnt_ext > MAX_USED) ? MAX_USED : cnt_ext;
    assign accept  = i_in.valid && i_ctrl.in_rdy;

    always_comb begin
        sample_ext = EXT_W'(i_in.sample);
        in_top     = sample_ext[EXT_W-1:STATE_BITS-1];
        in_ovf     = !((&in_top) || !(|in_top));
        if (in_ovf) begin
            in_sat = sample_ext[EXT_W-1] ? STATE_MIN : STATE_MAX;
        end else begin
            in_sat = $signed(sample_ext[STATE_BITS-1:0]);
        end

        cur_st = $signed(r_cur[STATE_BITS-1:0]);

        case (i_ctrl.coef_sel)
            CS_B0: begin
                coef = b0_tab[r_sec];
                opnd = cur_st;
            end
            CS_B1: begin
                coef = b1_tab[r_sec];
                opnd = r_hin1[r_sec];
            end
            CS_B2: begin
                coef = b2_tab[r_sec];
                opnd = r_hin2[r_sec];
            end
            CS_A1: begin
                coef = a1_tab[r_sec];
                opnd = r_hout1[r_sec];
            end
            CS_A2: begin
                coef = a2_tab[r_sec];
                opnd = r_hout2[r_sec];
            end
            default: begin
                coef = '0;
                opnd = '0;
            end
        endcase
        prod_next = coef * opnd;

        prod_ext = ACC_W'(r_prod);
        addend   = r_prod_neg ? -prod_ext : prod_ext;

        acc_rnd = r_acc + RND_HALF;
        acc_shr = acc_rnd >>> COEF_FRAC_BITS;
        acc_top = acc_shr[ACC_W-1:STATE_BITS-1];
        acc_ovf = !((&acc_top) || !(|acc_top));
        if (acc_ovf) begin
            acc_sat = acc_shr[ACC_W-1] ? STATE_MIN : STATE_MAX;
        end else begin
            acc_sat = $signed(acc_shr[STATE_BITS-1:0]);
        end

        filt_top = r_cur[EXT_W-1:SAMPLE_BITS-1];
        filt_ovf = !((&filt_top) || !(|filt_top));
        if (filt_ovf) begin
            filt_sat = r_cur[EXT_W-1] ? SMP_MIN : SMP_MAX;
        end else begin
            filt_sat = $signed(r_cur[SAMPLE_BITS-1:0]);
        end
        resid = (SAMPLE_BITS+1)'(r_sample) - (SAMPLE_BITS+1)'(filt_sat);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prime     <= 1'b1;
            r_sec       <= '0;
            r_out_valid <= 1'b0;
            for (int n = 0; n < MAX_SECTIONS; n++) begin
                r_hin1[n]  <= '0;
                r_hin2[n]  <= '0;
                r_hout1[n] <= '0;
                r_hout2[n] <= '0;
            end
        end else begin
            if (accept) begin
                r_cur    <= (used != '0) ? EXT_W'(in_sat) : sample_ext;
                r_sample <= i_in.sample;
                r_bend   <= i_in.block_end;
                r_clip   <= (used != '0) && in_ovf;
                r_sec    <= '0;
            end
            if (i_ctrl.mul_en) begin
                r_prod     <= prod_next;
                r_prod_neg <= i_ctrl.mul_neg;
            end
            if (i_ctrl.acc_en) begin
                r_acc <= i_ctrl.acc_clr ? addend : r_acc + addend;
            end
            if (i_ctrl.prime && r_prime) begin
                r_hin1[r_sec]  <= cur_st;
                r_hin2[r_sec]  <= cur_st;
                r_hout1[r_sec] <= dcz_tab[r_sec] ? '0 : cur_st;
                r_hout2[r_sec] <= dcz_tab[r_sec] ? '0 : cur_st;
            end
            if (i_ctrl.fin) begin
                r_hin2[r_sec]  <= r_hin1[r_sec];
                r_hin1[r_sec]  <= cur_st;
                r_hout2[r_sec] <= r_hout1[r_sec];
                r_hout1[r_sec] <= acc_sat;
                r_cur          <= EXT_W'(acc_sat);
                r_clip         <= r_clip | acc_ovf;
                r_sec          <= r_sec + SEC_W'(1);
            end
            if (i_ctrl.out_ld) begin
                r_out_valid <= 1'b1;
                r_filt      <= filt_sat;
                r_resid     <= resid;
                r_out_bend  <= r_bend;
                r_out_clip  <= r_clip | filt_ovf;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_hit) begin
                r_prime <= 1'b1;
            end else if (i_ctrl.out_ld) begin
                r_prime <= 1'b0;
            end
        end
    end

    assign i_in.ready          = i_ctrl.in_rdy && i_rst_n;
    assign o_out.valid         = r_out_valid;
    assign o_out.filtered      = r_filt;
    assign o_out.residual      = r_resid;
    assign o_out.block_end_out = r_out_bend;
    assign o_out.clipped       = r_out_clip;

    assign o_stat.in_valid  = i_in.valid;
    assign o_stat.out_block = r_out_valid && !o_out.ready;
    assign o_stat.no_sec    = (used == '0);
    assign o_stat.last_sec  = ((USED_W'(r_sec) + USED_W'(1)) == used);

endmodule

`default_nettype wire

>>> rtl/core/biquad_cascade_iir_filter_core.sv
// ----------------------------------------------------------------------------
// biquad_cascade_iir_filter_core
// cascade of up to four direct form 1 biquads on one shared multiplier,
// run by a microcoded sequencer; gives filtered and complementary output
// ----------------------------------------------------------------------------
//  channel   dir  handshake            payload
//  i_in      in   valid / ready        sample, block_end
//  o_out     out  valid / ready        filtered, residual, block_end_out, clipped
//  i_cfg_*   in   write enable only    index, data
//
//  each section in use runs as five products and two finishing steps on the
//  single multiplier; with no section in use an accepted sample goes
//  straight to the output step
//  reset is synchronous and active low; all histories clear and priming arms
//  results wait in an output register, the next sample is taken meanwhile;
//  a stalled output holds the sequencer at its output step
// ----------------------------------------------------------------------------
`default_nettype none

module biquad_cascade_iir_filter_core #(
    parameter int MAX_SECTIONS   = biq_pkg::MAX_SECTIONS_DEF,
    parameter int SAMPLE_BITS    = biq_pkg::SAMPLE_BITS_DEF,
    parameter int STATE_BITS     = biq_pkg::STATE_BITS_DEF,
    parameter int COEF_FRAC_BITS = biq_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [biq_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [biq_pkg::CFG_DATA_W-1:0] i_cfg_data,
    biq_in_if.sink                         i_in,
    biq_out_if.source                      o_out
);
    import biq_pkg::*;

    t_cfg  cfg;
    logic  cfg_hit;
    t_ctrl ctrl;
    t_stat stat;

    biq_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg),
        .o_cfg_hit   (cfg_hit)
    );

    biq_useq u_useq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_ctrl  (ctrl)
    );

    biq_datapath #(
        .MAX_SECTIONS   (MAX_SECTIONS),
        .SAMPLE_BITS    (SAMPLE_BITS),
        .STATE_BITS     (STATE_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_datapath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_cfg_hit (cfg_hit),
        .i_ctrl    (ctrl),
        .o_stat    (stat),
        .i_in      (i_in),
        .o_out     (o_out)
    );

endmodule

`default_nettype wire

>>> rtl/core/biq_checker.sv
// ----------------------------------------------------------------------------
// biq_checker
// port-level checks on the filter core, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module biq_checker #(
    parameter int SAMPLE_BITS = biq_pkg::SAMPLE_BITS_DEF
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_in_valid,
    input logic                   i_in_ready,
    input logic                   i_out_valid,
    input logic                   i_out_ready,
    input logic [SAMPLE_BITS-1:0] i_filtered,
    input logic [SAMPLE_BITS:0]   i_residual,
    input logic                   i_block_end_out,
    input logic                   i_clipped
);
    import biq_pkg::*;

    logic in_take;
    assign in_take = i_in_valid && i_in_ready;

    // stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_filtered) && $stable(i_residual)
            && $stable(i_block_end_out) && $stable(i_clipped))
        else $error("result changed while stalled");

    // one sample in flight at a time
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take |=> !i_in_ready)
        else $error("input ready right after a transaction");

    // output valid never rises straight after an input transaction
    a_min_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take |=> !$rose(i_out_valid))
        else $error("result appeared one cycle after input");

endmodule

bind biquad_cascade_iir_filter_core biq_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_biq_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in.valid),
    .i_in_ready      (i_in.ready),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_filtered      (o_out.filtered),
    .i_residual      (o_out.residual),
    .i_block_end_out (o_out.block_end_out),
    .i_clipped       (o_out.clipped)
);

`default_nettype wire

>>> sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the cascaded biquad iir filter core: a bit-exact
// software copy of the cascade predicts every result and a monitor compares
// each output transaction field by field; directed cases cover the reset
// setup, section counts, clipping and the spare register index, then random
// phases with fresh settings and random stalls on both channels
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
    import biq_pkg::*;

    localparam int CYCLE_LIMIT   = 500000;
    localparam int SETTLE_CYCLES = 40;
    localparam int RANDOM_PHASES = 15;
    localparam int PHASE_ITEMS   = 100;
    localparam int N_COEFS       = 5;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

    typedef struct packed {
        logic signed [SAMPLE_BITS_DEF-1:0] filtered;
        logic signed [SAMPLE_BITS_DEF:0]   residual;
        logic                              block_end;
        logic                              clipped;
    } result_t;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    biq_in_if  in_ch ();
    biq_out_if out_ch ();

    biquad_cascade_iir_filter_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    // filter state mirror
    logic [CFG_COUNT_W-1:0] count_reg;
    logic [CFG_MASK_W-1:0]  mask_reg;
    logic [CFG_DATA_W-1:0]  coef_reg [0:N_COEFS-1];
    longint                 x_d1 [0:PACK_SECTIONS-1];
    longint                 x_d2 [0:PACK_SECTIONS-1];
    longint                 y_d1 [0:PACK_SECTIONS-1];
    longint                 y_d2 [0:PACK_SECTIONS-1];
    bit                     prime_armed;

    result_t pending_results [$];
    int      n_errors;
    int      cycle_count;
    int      stall_pct;
    int      out_hold;

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    function automatic void mirror_reset();
        count_reg = COUNT_RESET;
        mask_reg  = MASK_RESET;
        for (int k = 0; k < N_COEFS; k++) coef_reg[k] = '0;
        coef_reg[CS_B0] = B0_RESET;
        for (int n = 0; n < PACK_SECTIONS; n++) begin
            x_d1[n] = 0;
            x_d2[n] = 0;
            y_d1[n] = 0;
            y_d2[n] = 0;
        end
        prime_armed = 1'b1;
    endfunction

    function automatic void mirror_write(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_SECTION_COUNT: count_reg = data[CFG_COUNT_W-1:0];
            CFG_DC_ZERO_MASK:  mask_reg = data[CFG_MASK_W-1:0];
            CFG_COEF_B0:       coef_reg[CS_B0] = data;
            CFG_COEF_B1:       coef_reg[CS_B1] = data;
            CFG_COEF_B2:       coef_reg[CS_B2] = data;
            CFG_COEF_A1:       coef_reg[CS_A1] = data;
            CFG_COEF_A2:       coef_reg[CS_A2] = data;
            default:           return;
        endcase
        prime_armed = 1'b1;
    endfunction

    function automatic longint coef_at(input int sel, input int sec);
        logic [CFG_DATA_W-1:0] word;
        logic [COEF_W-1:0]     field;
        word  = coef_reg[sel];
        field = word[sec*COEF_W +: COEF_W];
        return longint'($signed(field));
    endfunction

    function automatic longint clamp(input longint v, input int bits, inout bit clip);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (bits - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) begin
            clip = 1'b1;
            return hi;
        end
        if (v < lo) begin
            clip = 1'b1;
            return lo;
        end
        return v;
    endfunction

    function automatic result_t filter_step(input logic signed [SAMPLE_BITS_DEF-1:0] x,
                                            input logic be);
        result_t r;
        longint  cur;
        longint  acc;
        longint  diff;
        int      used;
        bit      clip;
        clip = 1'b0;
        used = (count_reg > PACK_SECTIONS) ? PACK_SECTIONS : int'(count_reg);
        cur  = x;
        if (used > 0) cur = clamp(cur, STATE_BITS_DEF, clip);
        for (int n = 0; n < used; n++) begin
            if (prime_armed) begin
                x_d1[n] = cur;
                x_d2[n] = cur;
                y_d1[n] = mask_reg[n] ? 0 : cur;
                y_d2[n] = mask_reg[n] ? 0 : cur;
            end
            acc = coef_at(CS_B0, n) * cur + coef_at(CS_B1, n) * x_d1[n]
                + coef_at(CS_B2, n) * x_d2[n] - coef_at(CS_A1, n) * y_d1[n]
                - coef_at(CS_A2, n) * y_d2[n];
            acc = (acc + (longint'(1) <<< (COEF_FRAC_BITS_DEF - 1))) >>> COEF_FRAC_BITS_DEF;
            acc = clamp(acc, STATE_BITS_DEF, clip);
            x_d2[n] = x_d1[n];
            x_d1[n] = cur;
            y_d2[n] = y_d1[n];
            y_d1[n] = acc;
            cur = acc;
        end
        prime_armed = 1'b0;
        cur = clamp(cur, SAMPLE_BITS_DEF, clip);
        diff = longint'(x) - cur;
        r.filtered  = cur[SAMPLE_BITS_DEF-1:0];
        r.residual  = diff[SAMPLE_BITS_DEF:0];
        r.block_end = be;
        r.clipped   = clip;
        return r;
    endfunction

    // sections with poles inside the stability triangle
    function automatic void stable_coefs(output logic [CFG_DATA_W-1:0] c [0:N_COEFS-1]);
        int a2v;
        int a1v;
        int lim;
        for (int k = 0; k < N_COEFS; k++) c[k] = '0;
        for (int n = 0; n < PACK_SECTIONS; n++) begin
            a2v = int'($urandom_range(15000, 0));
            lim = 16384 + a2v - 400;
            a1v = int'($urandom_range(2 * lim, 0)) - lim;
            c[CS_B0][n*COEF_W +: COEF_W] = 16'(int'($urandom_range(16383, 0)) - 8192);
            c[CS_B1][n*COEF_W +: COEF_W] = 16'(int'($urandom_range(16383, 0)) - 8192);
            c[CS_B2][n*COEF_W +: COEF_W] = 16'(int'($urandom_range(16383, 0)) - 8192);
            c[CS_A1][n*COEF_W +: COEF_W] = 16'(a1v);
            c[CS_A2][n*COEF_W +: COEF_W] = 16'(a2v);
        end
    endfunction

    task automatic send_sample(input logic signed [SAMPLE_BITS_DEF-1:0] s, input logic be);
        int gap;
        if ($urandom_range(99, 0) < stall_pct) begin
            gap = int'($urandom_range(6, 1));
            @(negedge i_clk);
            in_ch.valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        in_ch.valid     = 1'b1;
        in_ch.sample    = s;
        in_ch.block_end = be;
        do @(posedge i_clk); while (!in_ch.ready);
        pending_results.push_back(filter_step(s, be));
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        in_ch.valid = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(posedge i_clk);
        mirror_write(idx, data);
        @(negedge i_clk);
        cfg_we = 1'b0;
    endtask

    task automatic write_coefs(input logic [CFG_DATA_W-1:0] c [0:N_COEFS-1]);
        write_reg(CFG_COEF_B0, c[CS_B0]);
        write_reg(CFG_COEF_B1, c[CS_B1]);
        write_reg(CFG_COEF_B2, c[CS_B2]);
        write_reg(CFG_COEF_A1, c[CS_A1]);
        write_reg(CFG_COEF_A2, c[CS_A2]);
    endtask

    // reset setup is a single section, a plain gain of -1.0625 (b0 only)
    task automatic test_reset_passthrough();
        send_sample(16'sd0, 1'b0);
        send_sample(16'sd32767, 1'b1);
        send_sample(-16'sd32768, 1'b0);
        send_sample(-16'sd1, 1'b1);
        send_sample(16'sd1, 1'b0);
        send_sample(16'sh5555, 1'b1);
        send_sample(16'shAAAA, 1'b0);
    endtask

    task automatic test_section_counts();
        logic [CFG_DATA_W-1:0] c [0:N_COEFS-1];
        logic [CFG_COUNT_W-1:0] counts [0:4];
        counts = '{3'd0, 3'd2, 3'd4, 3'd5, 3'd7};
        wait_idle();
        stable_coefs(c);
        write_coefs(c);
        write_reg(CFG_DC_ZERO_MASK, 64'h5);
        foreach (counts[k]) begin
            wait_idle();
            write_reg(CFG_SECTION_COUNT, 64'(counts[k]));
            send_sample(16'(int'($urandom_range(8191, 0)) - 4096), 1'b0);
            send_sample(16'($urandom), 1'b1);
        end
    endtask

    task automatic test_clipping();
        logic [CFG_DATA_W-1:0] c [0:N_COEFS-1];
        wait_idle();
        // output clips while the section state stays in range
        write_reg(CFG_SECTION_COUNT, 64'd1);
        write_reg(CFG_DC_ZERO_MASK, 64'd0);
        c = '{64'h7FFF_7FFF_7FFF_7FFF, 64'd0, 64'd0, 64'd0, 64'd0};
        write_coefs(c);
        send_sample(16'sd32767, 1'b0);
        send_sample(-16'sd32768, 1'b1);
        // every coefficient at its extreme, state saturates
        wait_idle();
        write_reg(CFG_SECTION_COUNT, 64'd4);
        write_reg(CFG_DC_ZERO_MASK, 64'hF);
        c = '{64'h7FFF_7FFF_7FFF_7FFF, 64'h8000_8000_8000_8000, 64'h7FFF_7FFF_7FFF_7FFF,
              64'h8000_8000_8000_8000, 64'h8000_8000_8000_8000};
        write_coefs(c);
        send_sample(16'sd32767, 1'b0);
        send_sample(-16'sd32768, 1'b0);
        send_sample(16'sd32767, 1'b1);
    endtask

    // a write to the spare index must not re-prime the histories
    task automatic test_spare_index();
        logic [CFG_DATA_W-1:0] c [0:N_COEFS-1];
        wait_idle();
        stable_coefs(c);
        write_coefs(c);
        write_reg(CFG_SECTION_COUNT, 64'd2);
        send_sample(16'sd1000, 1'b0);
        send_sample(-16'sd3000, 1'b0);
        wait_idle();
        write_reg(CFG_SPARE, {$urandom, $urandom});
        send_sample(16'sd2500, 1'b0);
        send_sample(-16'sd700, 1'b1);
    endtask

    task automatic test_random();
        logic [CFG_DATA_W-1:0] c [0:N_COEFS-1];
        logic signed [SAMPLE_BITS_DEF-1:0] s;
        int walk;
        int mode;
        walk = 0;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            wait_idle();
            case ($urandom_range(2, 0))
                0:       stall_pct = 0;
                1:       stall_pct = 20;
                default: stall_pct = 50;
            endcase
            if (phase >= RANDOM_PHASES - 2) stall_pct = 0;
            if ($urandom_range(3, 0) == 0) begin
                for (int k = 0; k < N_COEFS; k++) c[k] = {$urandom, $urandom};
            end else begin
                stable_coefs(c);
            end
            if ($urandom_range(3, 0) != 0) write_reg(CFG_COEF_B0, c[CS_B0]);
            if ($urandom_range(3, 0) != 0) write_reg(CFG_COEF_B1, c[CS_B1]);
            if ($urandom_range(3, 0) != 0) write_reg(CFG_COEF_B2, c[CS_B2]);
            if ($urandom_range(3, 0) != 0) write_reg(CFG_COEF_A1, c[CS_A1]);
            if ($urandom_range(3, 0) != 0) write_reg(CFG_COEF_A2, c[CS_A2]);
            if ($urandom_range(3, 0) != 0) write_reg(CFG_DC_ZERO_MASK, {$urandom, $urandom});
            if ($urandom_range(4, 0) == 0)
                write_reg(CFG_SECTION_COUNT, 64'($urandom_range(7, 0)));
            else
                write_reg(CFG_SECTION_COUNT, 64'($urandom_range(4, 1)));
            if ($urandom_range(7, 0) == 0) write_reg(CFG_SPARE, {$urandom, $urandom});
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                mode = int'($urandom_range(9, 0));
                if (mode < 5) begin
                    walk += int'($urandom_range(1023, 0)) - 512;
                    if (walk > 32767) walk = 32767;
                    if (walk < -32768) walk = -32768;
                    s = 16'(walk);
                end else if (mode < 8) begin
                    s = 16'(int'($urandom_range(4095, 0)) - 2048);
                end else begin
                    s = 16'($urandom);
                end
                send_sample(s, $urandom_range(15, 0) == 0);
            end
        end
    endtask

    always @(negedge i_clk) begin
        if (out_hold > 0) begin
            out_ch.ready = 1'b0;
            out_hold--;
        end else if ($urandom_range(99, 0) < stall_pct) begin
            out_ch.ready = 1'b0;
            out_hold = int'($urandom_range(5, 0));
        end else begin
            out_ch.ready = 1'b1;
        end
    end

    always @(posedge i_clk) begin : result_monitor
        result_t want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected transaction: filtered %0d", out_ch.filtered);
                n_errors++;
            end else begin
                want = pending_results.pop_front();
                if (out_ch.filtered !== want.filtered) begin
                    $error("filtered: expected %0d, got %0d", want.filtered, out_ch.filtered);
                    n_errors++;
                end
                if (out_ch.residual !== want.residual) begin
                    $error("residual: expected %0d, got %0d", want.residual, out_ch.residual);
                    n_errors++;
                end
                if (out_ch.block_end_out !== want.block_end) begin
                    $error("block_end_out: expected %0d, got %0d", want.block_end,
                           out_ch.block_end_out);
                    n_errors++;
                end
                if (out_ch.clipped !== want.clipped) begin
                    $error("clipped: expected %0d, got %0d", want.clipped, out_ch.clipped);
                    n_errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        n_errors        = 0;
        cycle_count     = 0;
        stall_pct       = 30;
        out_hold        = 0;
        i_rst_n         = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = CFG_SECTION_COUNT;
        cfg_data        = '0;
        in_ch.valid     = 1'b0;
        in_ch.sample    = '0;
        in_ch.block_end = 1'b0;
        out_ch.ready    = 1'b0;
        mirror_reset();
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_passthrough();
        test_section_counts();
        test_clipping();
        test_spare_index();
        test_random();

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (n_errors == 0 && pending_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> files.f
rtl/core/biq_pkg.sv
rtl/core/biq_if.sv
rtl/core/biq_cfg_regs.sv
rtl/core/biq_useq.sv
rtl/core/biq_datapath.sv
rtl/core/biquad_cascade_iir_filter_core.sv
rtl/core/biq_checker.sv
sim/tb_top.sv
